// ===== hw/rtl/cptl_pkg.sv =====
`default_nettype none

package cptl_pkg;

  // Unit vectors and every product rescale use 28 fraction bits.
  localparam int UNIT_BITS = 28;

  // Latency of the normalizer and of the parameter divider, in cycles.
  localparam int NORM_LAT = 65;
  localparam int PDIV_LAT = 36;

  // Largest magnitude of the line parameters t and sa.
  localparam logic [34:0] PARAM_CAP = 35'h4_0000_0000;
  localparam logic signed [37:0] CAP_POS = 38'sh0_4_0000_0000;
  localparam logic signed [37:0] CAP_NEG = -38'sh0_4_0000_0000;

  // Limits of a signed 32-bit coordinate.
  localparam logic signed [39:0] SAT_MAX = 40'sh00_7FFF_FFFF;
  localparam logic signed [39:0] SAT_MIN = -40'sh00_8000_0000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_DEGEN    = 2'd2
  } status_e;

  // Words carried beside the normalizer.
  typedef struct packed {
    logic [2:0][31:0] pa;
    logic [2:0][31:0] pb;
    logic [2:0][32:0] w;
    logic             deg;
  } side_t;

  // Words carried through the projection and divider stages.
  typedef struct packed {
    logic [2:0][31:0] pa;
    logic [2:0][31:0] pb;
    logic [2:0][29:0] ua;
    logic [2:0][29:0] ub;
    logic [2:0][32:0] w;
    logic [29:0]      k;
    logic [35:0]      s;
    logic             deg;
    logic             par;
    logic             negt;
  } ctx_t;

  // Drop UNIT_BITS fraction bits, rounding halves away from zero.
  function automatic logic signed [71:0] rnd28(input logic signed [71:0] x);
    logic [71:0] m;
    logic [71:0] r;
    m = x[71] ? 72'(-x) : 72'(x);
    r = (m + (72'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
    return x[71] ? -$signed(r) : $signed(r);
  endfunction

  // Saturate to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [39:0] x);
    logic [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'h7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Clamp a line parameter to plus or minus PARAM_CAP.
  function automatic logic [35:0] clamp36(input logic signed [37:0] x);
    logic [35:0] r;
    if (x > CAP_POS) begin
      r = 36'(CAP_POS);
    end else if (x < CAP_NEG) begin
      r = 36'(CAP_NEG);
    end else begin
      r = x[35:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cptl_norm.sv =====
`default_nettype none

// Turns a nonzero 3D vector into a Q.28 unit vector in a fixed pipeline.
module cptl_norm (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [2:0][32:0] vec_i,
  output logic [2:0][29:0] unit_o
);

  localparam int SqSteps  = 29;
  localparam int DivSteps = 29;
  localparam logic [5:0] TopBit = 6'd27;

  logic [2:0][32:0] mag_d;
  logic [2:0][32:0] m1_q, m2_q;
  logic [2:0]       ng1_q, ng2_q, ng3_q, ng4_q;
  logic [32:0]      or1_q;
  logic [5:0]       pos_d, pos2_q;
  logic [2:0][27:0] ms_d, ms3_q, ms4_q;
  logic [2:0][55:0] sq4_q;

  logic [57:0]      sx_q  [0:SqSteps];
  logic [30:0]      sr_q  [0:SqSteps];
  logic [28:0]      sqq_q [0:SqSteps];
  logic [2:0][27:0] sms_q [0:SqSteps];
  logic [2:0]       sng_q [0:SqSteps];
  logic [30:0]      sr_d  [1:SqSteps];
  logic [28:0]      sqq_d [1:SqSteps];

  logic [2:0][56:0] nu_d;
  logic [2:0][56:0] dn_q [0:DivSteps];
  logic [2:0][28:0] dr_q [0:DivSteps];
  logic [2:0][28:0] dq_q [0:DivSteps];
  logic [28:0]      dl_q [0:DivSteps];
  logic [2:0]       dng_q [0:DivSteps];
  logic [2:0][28:0] dr_d [1:DivSteps];
  logic [2:0][28:0] dq_d [1:DivSteps];

  logic [2:0][29:0] unit_q;

  // Magnitudes of the components.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = vec_i[i][32] ? (33'd0 - vec_i[i]) : vec_i[i];
    end
  end

  // The leading one of the OR of the magnitudes is the leading one of the largest.
  always_comb begin
    pos_d = '0;
    for (int b = 0; b < 33; b++) begin
      if (or1_q[b]) begin
        pos_d = 6'(b);
      end
    end
  end

  // Scale so that the largest magnitude lies in [2^27, 2^28).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos2_q >= TopBit) begin
        ms_d[i] = 28'(m2_q[i] >> (pos2_q - TopBit));
      end else begin
        ms_d[i] = 28'(m2_q[i] << (TopBit - pos2_q));
      end
    end
  end

  // Square root, one result bit per stage.
  always_comb begin
    logic [32:0] r_sh;
    logic [32:0] trial;
    for (int j = 1; j <= SqSteps; j++) begin
      r_sh  = {sr_q[j-1], sx_q[j-1][(59 - 2*j) -: 2]};
      trial = 33'({sqq_q[j-1], 2'b01});
      if (r_sh >= trial) begin
        sr_d[j]  = 31'(r_sh - trial);
        sqq_d[j] = {sqq_q[j-1][27:0], 1'b1};
      end else begin
        sr_d[j]  = r_sh[30:0];
        sqq_d[j] = {sqq_q[j-1][27:0], 1'b0};
      end
    end
  end

  // Rounded numerators m * 2^28 + len / 2.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nu_d[i] = 57'({sms_q[SqSteps][i], 28'd0}) + 57'(sqq_q[SqSteps] >> 1);
    end
  end

  // Restoring division by the length, one quotient bit per stage.
  always_comb begin
    logic [29:0] rs;
    for (int j = 1; j <= DivSteps; j++) begin
      for (int i = 0; i < 3; i++) begin
        rs = {dr_q[j-1][i], dn_q[j-1][i][DivSteps - j]};
        if (rs >= {1'b0, dl_q[j-1]}) begin
          dr_d[j][i] = 29'(rs - {1'b0, dl_q[j-1]});
          dq_d[j][i] = {dq_q[j-1][i][27:0], 1'b1};
        end else begin
          dr_d[j][i] = rs[28:0];
          dq_d[j][i] = {dq_q[j-1][i][27:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q   <= mag_d;
      or1_q  <= mag_d[0] | mag_d[1] | mag_d[2];
      for (int i = 0; i < 3; i++) begin
        ng1_q[i] <= vec_i[i][32];
      end
      m2_q   <= m1_q;
      ng2_q  <= ng1_q;
      pos2_q <= pos_d;
      ms3_q  <= ms_d;
      ng3_q  <= ng2_q;
      ms4_q  <= ms3_q;
      ng4_q  <= ng3_q;
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= 56'(ms3_q[i]) * 56'(ms3_q[i]);
      end

      sx_q[0]  <= 58'(sq4_q[0]) + 58'(sq4_q[1]) + 58'(sq4_q[2]);
      sr_q[0]  <= '0;
      sqq_q[0] <= '0;
      sms_q[0] <= ms4_q;
      sng_q[0] <= ng4_q;
      for (int j = 1; j <= SqSteps; j++) begin
        sx_q[j]  <= sx_q[j-1];
        sr_q[j]  <= sr_d[j];
        sqq_q[j] <= sqq_d[j];
        sms_q[j] <= sms_q[j-1];
        sng_q[j] <= sng_q[j-1];
      end

      dn_q[0]  <= nu_d;
      for (int i = 0; i < 3; i++) begin
        dr_q[0][i] <= 29'(nu_d[i] >> DivSteps);
      end
      dq_q[0]  <= '0;
      dl_q[0]  <= sqq_q[SqSteps];
      dng_q[0] <= sng_q[SqSteps];
      for (int j = 1; j <= DivSteps; j++) begin
        dn_q[j]  <= dn_q[j-1];
        dr_q[j]  <= dr_d[j];
        dq_q[j]  <= dq_d[j];
        dl_q[j]  <= dl_q[j-1];
        dng_q[j] <= dng_q[j-1];
      end

      // Restore the signs.
      for (int i = 0; i < 3; i++) begin
        unit_q[i] <= dng_q[DivSteps][i] ? (30'd0 - {1'b0, dq_q[DivSteps][i]})
                                        : {1'b0, dq_q[DivSteps][i]};
      end
    end
  end

  assign unit_o = unit_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cptl_pdiv.sv =====
`default_nettype none

// Computes min(floor(num * 2^28 / den), 2^34) in a fixed pipeline.
module cptl_pdiv (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [61:0] den_i,
  output logic [34:0] quo_o
);

  localparam int Steps = 35;

  logic        ov_q [0:Steps];
  logic [6:0]  nl_q [0:Steps];
  logic [61:0] dv_q [0:Steps];
  logic [61:0] rm_q [0:Steps];
  logic [34:0] qt_q [0:Steps];
  logic [61:0] rm_d [1:Steps];
  logic [34:0] qt_d [1:Steps];
  logic        ov_d;

  // The quotient is over the cap when num * 2^28 >= (2^34 + 1) * den.
  assign ov_d = 97'({num_i, 28'd0}) >= (97'({den_i, 34'd0}) + 97'(den_i));

  // Restoring long division, one quotient bit per stage.
  always_comb begin
    logic [34:0] nlow;
    logic [62:0] rs;
    for (int j = 1; j <= Steps; j++) begin
      nlow = {nl_q[j-1], 28'd0};
      rs   = {rm_q[j-1], nlow[Steps - j]};
      if (rs >= {1'b0, dv_q[j-1]}) begin
        rm_d[j] = 62'(rs - {1'b0, dv_q[j-1]});
        qt_d[j] = {qt_q[j-1][33:0], 1'b1};
      end else begin
        rm_d[j] = rs[61:0];
        qt_d[j] = {qt_q[j-1][33:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ov_q[0] <= ov_d;
      nl_q[0] <= num_i[6:0];
      rm_q[0] <= 62'(num_i >> 7);
      dv_q[0] <= den_i;
      qt_q[0] <= '0;
      for (int j = 1; j <= Steps; j++) begin
        ov_q[j] <= ov_q[j-1];
        nl_q[j] <= nl_q[j-1];
        dv_q[j] <= dv_q[j-1];
        rm_q[j] <= rm_d[j];
        qt_q[j] <= qt_d[j];
      end
    end
  end

  assign quo_o = ov_q[Steps] ? cptl_pkg::PARAM_CAP : qt_q[Steps];

endmodule

`default_nettype wire

// ===== hw/rtl/closest_points_two_lines_3d.sv =====
`default_nettype none

// Closest points between two 3D lines given by start and end points in signed
// Q16.16. The block is a 114-stage pipeline that takes one word per cycle while
// the output is not stalled; the depth comes from the two bit-per-stage square
// root and divider chains of the normalizer and the 35-bit parameter divider.
// All stages move together: when a result waits at the output and out_ready_i
// is low, the whole pipeline holds and in_ready_o drops in the same cycle.
// The parallel tolerance register should only be written while no word is in
// flight.
module closest_points_two_lines_3d (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] a_start_x_i,
  input  logic signed [31:0] a_start_y_i,
  input  logic signed [31:0] a_start_z_i,
  input  logic signed [31:0] a_end_x_i,
  input  logic signed [31:0] a_end_y_i,
  input  logic signed [31:0] a_end_z_i,
  input  logic signed [31:0] b_start_x_i,
  input  logic signed [31:0] b_start_y_i,
  input  logic signed [31:0] b_start_z_i,
  input  logic signed [31:0] b_end_x_i,
  input  logic signed [31:0] b_end_y_i,
  input  logic signed [31:0] b_end_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] closest_a_x_o,
  output logic signed [31:0] closest_a_y_o,
  output logic signed [31:0] closest_a_z_o,
  output logic signed [31:0] closest_b_x_o,
  output logic signed [31:0] closest_b_y_o,
  output logic signed [31:0] closest_b_z_o,
  output logic [1:0]         status_o
);

  localparam int NL        = cptl_pkg::NORM_LAT;
  localparam int IX_KS     = 1;
  localparam int IX_FLAG   = 6;
  localparam int IX_DIVO   = IX_FLAG + cptl_pkg::PDIV_LAT;
  localparam int IX_T      = IX_DIVO + 1;
  localparam int IX_MUL    = IX_T + 1;
  localparam int IX_SA     = IX_MUL + 1;
  localparam int IX_LAST   = IX_SA + 1;
  localparam int CX_N      = IX_LAST + 1;
  localparam int PIPE_DEPTH = NL + CX_N + 2;
  localparam int VLD_T     = 1 + NL + IX_T;

  logic en;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic [31:0] tol_q;

  logic signed [31:0] as_in [3];
  logic signed [31:0] ae_in [3];
  logic signed [31:0] bs_in [3];
  logic signed [31:0] be_in [3];

  cptl_pkg::side_t  sd_d;
  cptl_pkg::side_t  sd_q [0:NL];
  logic [2:0][32:0] va_d, vb_d, va_q, vb_q;
  logic [2:0][29:0] ua_w, ub_w;

  cptl_pkg::ctx_t cx_d [0:CX_N-1];
  cptl_pkg::ctx_t cx_q [0:CX_N-1];

  logic signed [59:0] kp_d [3], kp_q [3];
  logic signed [62:0] sp_d [3], sp_q [3];
  logic [29:0]        k_d;
  logic [35:0]        s_d;
  logic signed [59:0] ak_d [3], ak_q [3];
  logic signed [65:0] as_d [3], as_q [3];
  logic signed [30:0] d_d [3], d_q [3];
  logic signed [36:0] c_d [3], c_q [3];
  logic signed [61:0] dd_q [3];
  logic signed [67:0] cd_q [3];
  logic [61:0]        den_q, den7_q;
  logic signed [69:0] num_q;
  logic [63:0]        mnum_d, mnum_q;
  logic               par_d, negt_d;
  logic [34:0]        quo;
  logic signed [35:0] t_d, t_q;
  logic signed [65:0] tk_q;
  logic signed [65:0] ubt_q [3];
  logic signed [35:0] sa_d, sa_q;
  logic [31:0]        q1_d [3], q1_q [3], q1b_q [3];
  logic signed [65:0] uas_q [3];

  logic [31:0]         cla_d [3], clb_d [3], cla_q [3], clb_q [3];
  cptl_pkg::status_e   st_d, st_q;

  // The whole pipeline advances unless a result waits at the output and out_ready_i is low.
  assign en          = !vld_q[PIPE_DEPTH-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[PIPE_DEPTH-1];

  // Control state: valid bits and the tolerance register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      tol_q <= '0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
      end
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
    end
  end

  // Input word: directions, start points, offset between the start points, degenerate flag.
  always_comb begin
    as_in = '{a_start_x_i, a_start_y_i, a_start_z_i};
    ae_in = '{a_end_x_i, a_end_y_i, a_end_z_i};
    bs_in = '{b_start_x_i, b_start_y_i, b_start_z_i};
    be_in = '{b_end_x_i, b_end_y_i, b_end_z_i};
    for (int i = 0; i < 3; i++) begin
      va_d[i]    = 33'(ae_in[i]) - 33'(as_in[i]);
      vb_d[i]    = 33'(be_in[i]) - 33'(bs_in[i]);
      sd_d.pa[i] = as_in[i];
      sd_d.pb[i] = bs_in[i];
      sd_d.w[i]  = 33'(bs_in[i]) - 33'(as_in[i]);
    end
    sd_d.deg = (va_d == '0) || (vb_d == '0);
  end

  cptl_norm u_norm_a (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (va_q),
    .unit_o (ua_w)
  );

  cptl_norm u_norm_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (vb_q),
    .unit_o (ub_w)
  );

  // Context words along the projection stages.
  always_comb begin
    cx_d[0]      = '0;
    cx_d[0].pa   = sd_q[NL].pa;
    cx_d[0].pb   = sd_q[NL].pb;
    cx_d[0].w    = sd_q[NL].w;
    cx_d[0].deg  = sd_q[NL].deg;
    cx_d[0].ua   = ua_w;
    cx_d[0].ub   = ub_w;
    for (int j = 1; j < CX_N; j++) begin
      cx_d[j] = cx_q[j-1];
    end
    cx_d[IX_KS].k       = k_d;
    cx_d[IX_KS].s       = s_d;
    cx_d[IX_FLAG].par   = par_d;
    cx_d[IX_FLAG].negt  = negt_d;
  end

  // Dot products and projections up to the parameter division.
  always_comb begin
    logic signed [61:0] ksum;
    logic signed [64:0] ssum;
    logic signed [71:0] kr, sr, ar, asr;
    logic signed [69:0] mn;
    for (int i = 0; i < 3; i++) begin
      kp_d[i] = 60'($signed(ua_w[i])) * 60'($signed(ub_w[i]));
      sp_d[i] = 63'($signed(ua_w[i])) * 63'($signed(sd_q[NL].w[i]));
    end
    ksum = 62'(kp_q[0]) + 62'(kp_q[1]) + 62'(kp_q[2]);
    ssum = 65'(sp_q[0]) + 65'(sp_q[1]) + 65'(sp_q[2]);
    kr   = cptl_pkg::rnd28(72'(ksum));
    sr   = cptl_pkg::rnd28(72'(ssum));
    k_d  = kr[29:0];
    s_d  = sr[35:0];
    for (int i = 0; i < 3; i++) begin
      ak_d[i] = 60'($signed(cx_q[IX_KS].ua[i])) * 60'($signed(cx_q[IX_KS].k));
      as_d[i] = 66'($signed(cx_q[IX_KS].ua[i])) * 66'($signed(cx_q[IX_KS].s));
      ar      = cptl_pkg::rnd28(72'(ak_q[i]));
      asr     = cptl_pkg::rnd28(72'(as_q[i]));
      d_d[i]  = 31'($signed(cx_q[IX_KS+1].ub[i])) - 31'(ar);
      c_d[i]  = 37'($signed(cx_q[IX_KS+1].w[i])) - 37'(asr);
    end
    par_d  = den_q <= 62'({tol_q, 24'd0});
    negt_d = !num_q[69] && (num_q != '0);
    mn     = num_q[69] ? -num_q : num_q;
    mnum_d = mn[63:0];
  end

  cptl_pdiv u_pdiv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mnum_q),
    .den_i (den7_q),
    .quo_o (quo)
  );

  // Closest points from the line parameters.
  always_comb begin
    logic signed [71:0] tkr, ubr, uar;
    t_d  = cx_q[IX_DIVO].negt ? (36'sd0 - $signed({1'b0, quo})) : $signed({1'b0, quo});
    tkr  = cptl_pkg::rnd28(72'(tk_q));
    sa_d = $signed(cptl_pkg::clamp36(38'($signed(cx_q[IX_MUL].s)) + 38'(tkr)));
    for (int i = 0; i < 3; i++) begin
      ubr     = cptl_pkg::rnd28(72'(ubt_q[i]));
      q1_d[i] = cptl_pkg::sat32(40'($signed(cx_q[IX_MUL].pb[i])) + 40'(ubr));
    end
    st_d = cptl_pkg::ST_OK;
    if (cx_q[IX_LAST].deg) begin
      st_d = cptl_pkg::ST_DEGEN;
    end else if (cx_q[IX_LAST].par) begin
      st_d = cptl_pkg::ST_PARALLEL;
    end
    for (int i = 0; i < 3; i++) begin
      uar      = cptl_pkg::rnd28(72'(uas_q[i]));
      cla_d[i] = cptl_pkg::sat32(40'($signed(cx_q[IX_LAST].pa[i])) + 40'(uar));
      clb_d[i] = q1b_q[i];
      if (st_d != cptl_pkg::ST_OK) begin
        cla_d[i] = '0;
        clb_d[i] = '0;
      end
    end
  end

  // Data registers of every stage.
  always_ff @(posedge clk_i) begin
    if (en) begin
      va_q  <= va_d;
      vb_q  <= vb_d;
      sd_q[0] <= sd_d;
      for (int j = 1; j <= NL; j++) begin
        sd_q[j] <= sd_q[j-1];
      end
      for (int j = 0; j < CX_N; j++) begin
        cx_q[j] <= cx_d[j];
      end
      kp_q  <= kp_d;
      sp_q  <= sp_d;
      ak_q  <= ak_d;
      as_q  <= as_d;
      d_q   <= d_d;
      c_q   <= c_d;
      for (int i = 0; i < 3; i++) begin
        dd_q[i] <= 62'(d_q[i]) * 62'(d_q[i]);
        cd_q[i] <= 68'(c_q[i]) * 68'(d_q[i]);
      end
      den_q  <= 62'(dd_q[0]) + 62'(dd_q[1]) + 62'(dd_q[2]);
      num_q  <= 70'(cd_q[0]) + 70'(cd_q[1]) + 70'(cd_q[2]);
      mnum_q <= mnum_d;
      den7_q <= den_q;
      t_q    <= t_d;
      tk_q   <= 66'(t_q) * 66'($signed(cx_q[IX_T].k));
      for (int i = 0; i < 3; i++) begin
        ubt_q[i] <= 66'($signed(cx_q[IX_T].ub[i])) * 66'(t_q);
      end
      sa_q   <= sa_d;
      q1_q   <= q1_d;
      for (int i = 0; i < 3; i++) begin
        uas_q[i] <= 66'($signed(cx_q[IX_SA].ua[i])) * 66'(sa_q);
      end
      q1b_q  <= q1_q;
      cla_q  <= cla_d;
      clb_q  <= clb_d;
      st_q   <= st_d;
    end
  end

  assign closest_a_x_o = cla_q[0];
  assign closest_a_y_o = cla_q[1];
  assign closest_a_z_o = cla_q[2];
  assign closest_b_x_o = clb_q[0];
  assign closest_b_y_o = clb_q[1];
  assign closest_b_z_o = clb_q[2];
  assign status_o      = st_q;

  // A result that is not ok carries zero points.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != cptl_pkg::ST_OK)) |->
      (closest_a_x_o == 0 && closest_a_y_o == 0 && closest_a_z_o == 0 &&
       closest_b_x_o == 0 && closest_b_y_o == 0 && closest_b_z_o == 0))
    else $error("non-ok result carries nonzero points");

  // A degenerate word that moves into the output register reports so.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[PIPE_DEPTH-2] && en && cx_q[IX_LAST].deg) |=>
      (status_o == cptl_pkg::ST_DEGEN))
    else $error("degenerate line lost its status");

  // The line parameter from the divider stays within the cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[VLD_T] |-> ((t_q <= 36'(cptl_pkg::CAP_POS)) && (t_q >= 36'(cptl_pkg::CAP_NEG))))
    else $error("line parameter exceeds the cap");

endmodule

`default_nettype wire
